### hdl/handle_translation_table_top_assert.svh
`ifndef HANDLE_TRANSLATION_TABLE_TOP_ASSERT_SVH
`define HANDLE_TRANSLATION_TABLE_TOP_ASSERT_SVH

// same-cycle implication on the rising clock edge, off during reset
`define HTT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("htt assertion failed");

// next-cycle implication on the rising clock edge, off during reset
`define HTT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("htt assertion failed");

`endif

### hdl/htt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package htt_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int VALUE_W         = 64;
   localparam int ID_W            = 32;
   localparam int TYPE_W          = 3;
   localparam int STATUS_W        = 2;

   localparam logic [ID_W-1:0] FIRST_ID_RESET = 32'd1;

   localparam logic CMD_OUT = 1'b0;
   localparam logic CMD_IN  = 1'b1;

   localparam logic [TYPE_W-1:0] OBJ_BINDER      = 3'd0;
   localparam logic [TYPE_W-1:0] OBJ_HANDLE      = 3'd1;
   localparam logic [TYPE_W-1:0] OBJ_WEAK_BINDER = 3'd2;
   localparam logic [TYPE_W-1:0] OBJ_WEAK_HANDLE = 3'd3;
   localparam logic [TYPE_W-1:0] OBJ_FD          = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN_ID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_TYPE   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_FETCH,
      S_SCAN,
      S_DELIVER
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

### hdl/htt_store.sv
`timescale 1ns / 1ps
`default_nettype none

module htt_store #(
   parameter int TABLE_DEPTH = htt_pkg::TABLE_DEPTH_DEF,
   parameter int AW          = $clog2(htt_pkg::TABLE_DEPTH_DEF)
) (
   input  wire logic                        clock,
   input  wire htt_pkg::mem_ctl_type        mem_ctl,
   input  wire logic [AW-1:0]               rd_addr,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [htt_pkg::VALUE_W-1:0] wr_data,
   output logic      [htt_pkg::VALUE_W-1:0] rd_data
);
   import htt_pkg::*;

   logic [VALUE_W-1:0] mem [TABLE_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/htt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module htt_ctrl #(
   parameter int TABLE_DEPTH = htt_pkg::TABLE_DEPTH_DEF,
   parameter int AW          = $clog2(htt_pkg::TABLE_DEPTH_DEF),
   parameter int CW          = $clog2(htt_pkg::TABLE_DEPTH_DEF + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [htt_pkg::ID_W-1:0]      first_id,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_cmd,
   input  wire logic [htt_pkg::TYPE_W-1:0]    req_obj_type,
   input  wire logic [htt_pkg::VALUE_W-1:0]   req_obj_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [htt_pkg::VALUE_W-1:0]   rsp_result_value,
   output logic      [htt_pkg::STATUS_W-1:0]  rsp_status,
   output htt_pkg::mem_ctl_type               mem_ctl,
   output logic      [AW-1:0]                 rd_addr,
   output logic      [AW-1:0]                 wr_addr,
   output logic      [htt_pkg::VALUE_W-1:0]   wr_data,
   input  wire logic [htt_pkg::VALUE_W-1:0]   rd_data
);
   import htt_pkg::*;

   state_type           state_ff, state_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       scan_idx_ff, scan_idx_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       pend_idx_ff, pend_idx_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [VALUE_W-1:0]  base;
   logic [VALUE_W-1:0]  id_diff;
   logic                issue;
   logic                match;

   assign base    = {{(VALUE_W-ID_W){1'b0}}, first_id};
   assign id_diff = value_ff - base;
   assign issue   = (scan_idx_ff < count_ff);
   assign match   = pend_ff && (rd_data == value_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      scan_idx_ff   <= scan_idx_in;
      pend_idx_ff   <= pend_idx_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_ctl       = '0;
      rd_addr       = scan_idx_ff[AW-1:0];
      wr_addr       = count_ff[AW-1:0];
      wr_data       = value_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in = req_obj_value;
               unique case (req_obj_type) inside
                  OBJ_BINDER: begin
                     if (req_cmd == CMD_IN) begin
                        state_in = S_LOOKUP;
                     end else begin
                        scan_idx_in = '0;
                        pend_in     = 1'b0;
                        state_in    = S_SCAN;
                     end
                  end
                  OBJ_HANDLE, OBJ_WEAK_BINDER, OBJ_WEAK_HANDLE, OBJ_FD: begin
                     res_value_in  = req_obj_value;
                     res_status_in = ST_OK;
                     state_in      = S_DELIVER;
                  end
                  default: begin
                     res_value_in  = '0;
                     res_status_in = ST_BAD_TYPE;
                     state_in      = S_DELIVER;
                  end
               endcase
            end
         end
         S_LOOKUP: begin
            if ((value_ff < base) || (id_diff >= VALUE_W'(count_ff))) begin
               res_value_in  = '0;
               res_status_in = ST_UNKNOWN_ID;
               state_in      = S_DELIVER;
            end else begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = id_diff[AW-1:0];
               state_in      = S_FETCH;
            end
         end
         S_FETCH: begin
            res_value_in  = rd_data;
            res_status_in = ST_OK;
            state_in      = S_DELIVER;
         end
         S_SCAN: begin
            // one read issued and one compare per cycle
            if (issue) begin
               mem_ctl.rd_en = 1'b1;
               scan_idx_in   = scan_idx_ff + 1'b1;
               pend_in       = 1'b1;
               pend_idx_in   = scan_idx_ff[AW-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (match) begin
               res_value_in  = base + VALUE_W'(pend_idx_ff);
               res_status_in = ST_OK;
               state_in      = S_DELIVER;
            end else if (!issue) begin
               if (count_ff == CW'(TABLE_DEPTH)) begin
                  res_value_in  = '0;
                  res_status_in = ST_FULL;
               end else begin
                  mem_ctl.wr_en = 1'b1;
                  res_value_in  = base + VALUE_W'(count_ff);
                  res_status_in = ST_OK;
                  count_in      = count_ff + 1'b1;
               end
               state_in = S_DELIVER;
            end
         end
         S_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

### hdl/handle_translation_table_top.sv
// accept to result: pass-through and invalid types go from idle to deliver;
// an inbound binder goes through lookup, fetch (skipped for an unknown id) and
// deliver; an outbound binder scans its n stored addresses through the memory
// read port; a result stall holds deliver; a new word is taken only in idle
// reset: synchronous, clears the entry count and handshake state; first_id
// returns to 1 and stored addresses are undefined until written
`timescale 1ns / 1ps
`default_nettype none

module handle_translation_table_top #(
   parameter int TABLE_DEPTH = htt_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [htt_pkg::ID_W-1:0]      csr_first_id,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_cmd,
   input  wire logic [htt_pkg::TYPE_W-1:0]    req_obj_type,
   input  wire logic [htt_pkg::VALUE_W-1:0]   req_obj_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [htt_pkg::VALUE_W-1:0]   rsp_result_value,
   output logic      [htt_pkg::STATUS_W-1:0]  rsp_status
);
   import htt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [ID_W-1:0]    first_id_ff;
   mem_ctl_type        mem_ctl;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [VALUE_W-1:0] rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_id_ff <= FIRST_ID_RESET;
      end else if (csr_valid && csr_ready) begin
         first_id_ff <= csr_first_id;
      end
   end

   htt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW),
      .CW          (CW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .first_id         (first_id_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_obj_type     (req_obj_type),
      .req_obj_value    (req_obj_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .mem_ctl          (mem_ctl),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_data          (rd_data)
   );

   htt_store #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

### hdl/htt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "handle_translation_table_top_assert.svh"

module htt_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [htt_pkg::VALUE_W-1:0]   rsp_result_value,
   input wire logic [htt_pkg::STATUS_W-1:0]  rsp_status
);
   import htt_pkg::*;

   // a stalled result word holds
   `HTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_result_value) && $stable(rsp_status))

   // every error status carries a zero value
   `HTT_ASSERT_NOW(a_err_zero, rsp_valid && (rsp_status != ST_OK),
      rsp_result_value == '0)

   // one word in work at a time
   `HTT_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

endmodule

bind handle_translation_table_top htt_checker u_htt_checker (.*);

`default_nettype wire
